// ===== design/crcfr_pkg.sv =====
package crcfr_pkg;

  // frame layout and check limits
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
  localparam logic [8:0]  COUNT_MAX      = 9'd256;
  localparam logic [7:0]  MIN_FRAME      = 8'd5;

  // byte positions of the header fields
  localparam logic [8:0] IDX_ADDRESS = 9'd0;
  localparam logic [8:0] IDX_COMMAND = 9'd1;
  localparam logic [8:0] IDX_SIZE    = 9'd2;

  // configuration register map
  localparam int unsigned PADDR_W     = 1;
  localparam int unsigned PDATA_W     = 32;
  localparam logic [PADDR_W-1:0] ADDR_CRC_POLY = 1'b0;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_BAD_SIZE = 2'd2,
    STATUS_CRC_ERR  = 2'd3
  } frame_status_e;

endpackage

// ===== design/crcfr_if.sv =====
// received byte channel
interface crcfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

// frame check result channel
interface crcfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic [7:0] frame_address;
  logic [7:0] frame_command;
  logic [7:0] frame_size;

  modport source (output valid, output frame_status, output frame_address,
                  output frame_command, output frame_size, input ready);
  modport sink   (input valid, input frame_status, input frame_address,
                  input frame_command, input frame_size, output ready);
endinterface

// ===== design/crcfr_cfg_regs.sv =====
module crcfr_cfg_regs
  import crcfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [15:0]        crc_poly_o
);

  logic [15:0] crc_poly_q;
  logic        poly_wr;

  // write strobe on the access phase
  assign poly_wr = psel && penable && pwrite && (paddr == ADDR_CRC_POLY);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_poly_q <= CRC_POLY_RESET;
    end else if (poly_wr) begin
      crc_poly_q <= pwdata[15:0];
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_CRC_POLY) begin
      prdata = {{(PDATA_W-16){1'b0}}, crc_poly_q};
    end
  end

  assign crc_poly_o = crc_poly_q;

endmodule

// ===== design/crcfr_frame_check.sv =====
module crcfr_frame_check
  import crcfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] crc_poly_i,
  crcfr_in_if.sink    rx_i,
  crcfr_out_if.source res_o
);

  // one byte through the msb-first crc, bit at a time
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // per-buffer state
  logic [8:0]  count_q, count_d;
  logic [15:0] crc_run_q, crc_run_d;
  logic [7:0]  hdr_addr_q, hdr_addr_d;
  logic [7:0]  hdr_cmd_q, hdr_cmd_d;
  logic [7:0]  hdr_size_q, hdr_size_d;
  logic [15:0] crc_rx_q, crc_rx_d;

  // result register
  logic          res_valid_q;
  frame_status_e res_status_q, status_d;
  logic [7:0]    res_addr_q;
  logic [7:0]    res_cmd_q;
  logic [7:0]    res_size_q;

  logic out_free;
  logic proc;
  logic in_take;
  logic [8:0] size_ext;
  logic [8:0] crc_lo_idx;
  logic [8:0] crc_hi_idx;

  // a last byte needs a free result slot, other bytes go straight through
  assign out_free = !res_valid_q || res_o.ready;
  assign proc     = in_valid_q && (!in_last_q || out_free);
  assign rx_i.ready = !in_valid_q || proc;
  assign in_take  = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_i.rx_byte;
      in_last_q <= rx_i.end_of_buffer;
    end
  end

  // header capture, crc and byte count for the current byte
  always_comb begin
    hdr_addr_d = hdr_addr_q;
    hdr_cmd_d  = hdr_cmd_q;
    hdr_size_d = hdr_size_q;
    crc_run_d  = crc_run_q;
    crc_rx_d   = crc_rx_q;

    unique case (count_q)
      IDX_ADDRESS: hdr_addr_d = in_byte_q;
      IDX_COMMAND: hdr_cmd_d  = in_byte_q;
      IDX_SIZE:    hdr_size_d = in_byte_q;
      default: ;
    endcase

    size_ext   = {1'b0, hdr_size_d};
    crc_lo_idx = size_ext - 9'd2;
    crc_hi_idx = size_ext - 9'd1;

    if (count_q <= IDX_SIZE) begin
      crc_run_d = crc_byte(crc_run_q, in_byte_q, crc_poly_i);
    end else if (count_q < COUNT_MAX && hdr_size_d >= MIN_FRAME) begin
      if (count_q < crc_lo_idx) begin
        crc_run_d = crc_byte(crc_run_q, in_byte_q, crc_poly_i);
      end else if (count_q == crc_lo_idx) begin
        crc_rx_d = {crc_rx_q[15:8], in_byte_q};
      end else if (count_q == crc_hi_idx) begin
        crc_rx_d = {in_byte_q, crc_rx_q[7:0]};
      end
    end

    count_d = (count_q < COUNT_MAX) ? count_q + 9'd1 : count_q;

    // status on the last byte
    if (count_d < {1'b0, MIN_FRAME}) begin
      status_d = STATUS_SHORT;
    end else if (hdr_size_d < MIN_FRAME || size_ext > count_d) begin
      status_d = STATUS_BAD_SIZE;
    end else if (crc_run_d != crc_rx_d) begin
      status_d = STATUS_CRC_ERR;
    end else begin
      status_d = STATUS_OK;
    end
  end

  // per-buffer state, cleared after each result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      crc_run_q  <= CRC_INIT;
      hdr_addr_q <= '0;
      hdr_cmd_q  <= '0;
      hdr_size_q <= '0;
      crc_rx_q   <= '0;
    end else if (proc) begin
      if (in_last_q) begin
        count_q    <= '0;
        crc_run_q  <= CRC_INIT;
        hdr_addr_q <= '0;
        hdr_cmd_q  <= '0;
        hdr_size_q <= '0;
        crc_rx_q   <= '0;
      end else begin
        count_q    <= count_d;
        crc_run_q  <= crc_run_d;
        hdr_addr_q <= hdr_addr_d;
        hdr_cmd_q  <= hdr_cmd_d;
        hdr_size_q <= hdr_size_d;
        crc_rx_q   <= crc_rx_d;
      end
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (proc && in_last_q) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (proc && in_last_q) begin
      res_status_q <= status_d;
      res_addr_q   <= hdr_addr_d;
      res_cmd_q    <= hdr_cmd_d;
      res_size_q   <= hdr_size_d;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.frame_status  = res_status_q;
  assign res_o.frame_address = res_addr_q;
  assign res_o.frame_command = res_cmd_q;
  assign res_o.frame_size    = res_size_q;

endmodule

// ===== design/crc16_frame_receiver_check.sv =====
// CRC-16 framed buffer check.
// rx_i takes the received buffer one byte per word, end_of_buffer set on the
// last byte. A frame is address, command, total size, payload, CRC low, CRC
// high. The CRC runs MSB-first from 0xFFFF over the first size-2 bytes with
// the polynomial in register crc_poly (address 0, reset 0x1021).
// res_o gives one word per buffer, on its last byte: status (0 ok, 1 short,
// 2 bad size, 3 CRC mismatch) with the address, command and size bytes.
// Throughput is one byte per cycle: the byte is held in an input register
// and the byte-wise CRC update (eight shift/xor steps) is combinational
// before the result register. The result word is registered: it is loaded
// once the last byte sits in the input register and a result slot is free.
// When res_o stalls, bytes keep flowing until a last byte reaches the input
// register; that byte then waits and rx_i.ready drops until the pending
// result is taken.
// Reset clears the frame state and restores crc_poly to 0x1021; the block
// is ready for the first byte right after reset.
module crc16_frame_receiver_check
  import crcfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  crcfr_in_if.sink           rx_i,
  crcfr_out_if.source        res_o
);

  logic [15:0] crc_poly;

  // configuration registers
  crcfr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .crc_poly_o (crc_poly)
  );

  // byte pipeline and frame check
  crcfr_frame_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .crc_poly_i (crc_poly),
    .rx_i       (rx_i),
    .res_o      (res_o)
  );

endmodule
